// File: hw/rtl/srrw_pkg.sv
// ---------------------------------------------------------------------------
// Selective-repeat receiver window package
// Shared types and constants for the receive window: beat layouts of the
// packet and result channels, field widths and result kind codes.
// ---------------------------------------------------------------------------
package srrw_pkg;

  // Field widths.
  localparam int SEQ_W     = 31;
  localparam int WORD_W    = 32;
  localparam int CFG_W     = 6;
  localparam int BYTES_MAX = 20;
  localparam int PAYLOAD_W = 8 * BYTES_MAX;

  // Bytes at or above this index are never part of the payload.
  localparam int PAYLOAD_BYTES = 20;

  // The byte sum is built from groups of bytes added in parallel.
  localparam int GROUPS      = 4;
  localparam int GROUP_BYTES = BYTES_MAX / GROUPS;
  localparam int GROUP_SUM_W = 11;

  // Window defaults and limits.
  localparam int                 WINDOW_SLOTS_DEFAULT = 64;
  localparam int                 WIN_CAP              = 32;
  localparam logic [CFG_W-1:0]   WINDOW_SIZE_RST      = 6'd8;
  localparam logic [WORD_W-1:0]  ACK_SEQ              = 32'd1;

  // Result kind codes.
  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  // One arriving data packet.
  typedef struct packed {
    logic [SEQ_W-1:0]         received_seq;
    logic signed [WORD_W-1:0] received_ack;
    logic signed [WORD_W-1:0] received_checksum;
    logic [63:0]              payload_low;
    logic [63:0]              payload_mid;
    logic [31:0]              payload_high;
  } packet_t;

  // One result beat.
  typedef struct packed {
    logic                     result_kind;
    logic [SEQ_W-1:0]         packet_number;
    logic signed [WORD_W-1:0] ack_checksum;
    logic [63:0]              out_payload_low;
    logic [63:0]              out_payload_mid;
    logic [31:0]              out_payload_high;
    logic                     last_of_run;
  } result_t;

endpackage

// File: hw/rtl/selective_repeat_receiver_window.sv
// ---------------------------------------------------------------------------
// Selective-repeat receiver window
// Checks each data packet, acknowledges each one that passes, keeps it in a ring of slots and
// delivers the in-order run that starts at the window base.
// ---------------------------------------------------------------------------
// A packet is taken when start is high and busy is low. If it passes the
// checksum and window tests, its acknowledgement appears on the result port
// after the normalise, sum and decide states, and any in-order deliveries
// follow in the very next cycles, one per cycle, the last beat marked by
// last_of_run. Results are strobed for one cycle only: the receiver has no
// means to stall them. busy stays high while a packet is worked on, through
// the last of the deliveries it releases (0 to 32); the delivery run is
// paced by the single read port of the slot memory. After reset the slot
// memory is swept clear, one slot per cycle, with busy high; the window size
// register may be written at any time the block is idle, including during
// that sweep.
// ---------------------------------------------------------------------------
module selective_repeat_receiver_window #(
  parameter int WINDOW_SLOTS = srrw_pkg::WINDOW_SLOTS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Packet channel.
  input  logic                        start,
  output logic                        busy,
  input  srrw_pkg::packet_t           item_i,
  // Result channel.
  output logic                        result_valid_o,
  output srrw_pkg::result_t           result_o,
  // Window size register write channel.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [srrw_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int IdxW   = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int HalfSl = WINDOW_SLOTS / 2;
  localparam int WinCap = (HalfSl < srrw_pkg::WIN_CAP) ? HalfSl : srrw_pkg::WIN_CAP;
  localparam int PW     = srrw_pkg::PAYLOAD_W;
  localparam int NB     = srrw_pkg::BYTES_MAX;
  localparam int GW     = srrw_pkg::GROUP_SUM_W;
  localparam int WW     = srrw_pkg::WORD_W;
  localparam int SW     = srrw_pkg::SEQ_W;
  localparam int CW     = srrw_pkg::CFG_W;

  // Controller states.
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_NORM   = 3'd2;
  localparam logic [2:0] ST_SUM    = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_SCAN   = 3'd5;

  // One slot of the ring: filled flag and the stored payload.
  typedef struct packed {
    logic          filled;
    logic [PW-1:0] payload;
  } slot_t;

  // Ring index addition, wrapped once at the slot count.
  function automatic logic [IdxW-1:0] slot_add(input logic [IdxW-1:0] a,
                                               input logic [IdxW-1:0] b);
    logic [IdxW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IdxW + 1)'(WINDOW_SLOTS)) begin
      s = s - (IdxW + 1)'(WINDOW_SLOTS);
    end
    return s[IdxW-1:0];
  endfunction

  logic [2:0]           state_q, state_d;
  logic [CW-1:0]        win_size_q;
  logic [WW-1:0]        base_q, base_d;
  logic [IdxW-1:0]      base_idx_q, base_idx_d;
  logic [IdxW-1:0]      scan_idx_q, scan_idx_d;
  logic [CW-1:0]        scan_cnt_q, scan_cnt_d;
  srrw_pkg::packet_t    in_q;
  logic [PW-1:0]        norm_q;
  logic signed [GW-1:0] gsum_q [srrw_pkg::GROUPS];
  logic [WW-1:0]        psum_q;
  logic [SW-1:0]        pend_num_q, pend_num_d;
  logic [PW-1:0]        pend_pay_q, pend_pay_d;
  logic                 res_valid_q, res_valid_d;
  srrw_pkg::result_t    res_q, res_d;

  slot_t                mem [WINDOW_SLOTS];
  slot_t                rd_q;
  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  slot_t                mem_wdata;
  logic [IdxW-1:0]      mem_raddr;

  logic                 accept;
  logic [CW-1:0]        eff_w;
  logic [PW-1:0]        raw_pay;
  logic [PW-1:0]        norm_pay;
  logic [NB-1:0]        zero_flag;
  logic signed [GW-1:0] gsum [srrw_pkg::GROUPS];
  logic [WW-1:0]        gtotal;
  logic [WW:0]          seq_x, base_x, w_x, diff_x;
  logic                 sum_ok, below, above, is_old, at_base, pass;
  logic [IdxW-1:0]      seq_idx;
  logic [WW-1:0]        deliver_num;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // The window size is taken only while no packet is being worked on.
  assign cfg_ready_o = (state_q == ST_IDLE) || (state_q == ST_CLEAR);

  // Effective window: the register saturated to the ring capacity.
  assign eff_w = (win_size_q < CW'(WinCap)) ? win_size_q : CW'(WinCap);

  // Payload normalisation: a byte is kept only if no earlier byte is zero.
  assign raw_pay = {in_q.payload_high, in_q.payload_mid, in_q.payload_low};
  always_comb begin
    for (int i = 0; i < NB; i++) begin
      zero_flag[i] = (raw_pay[8*i +: 8] == 8'd0) || (i >= srrw_pkg::PAYLOAD_BYTES);
    end
    for (int i = 0; i < NB; i++) begin
      if (zero_flag[i] || (|(zero_flag & ((NB'(1) << i) - NB'(1))))) begin
        norm_pay[8*i +: 8] = 8'd0;
      end else begin
        norm_pay[8*i +: 8] = raw_pay[8*i +: 8];
      end
    end
  end

  // Signed byte sums, one small adder chain per group.
  always_comb begin
    for (int g = 0; g < srrw_pkg::GROUPS; g++) begin
      gsum[g] = '0;
      for (int j = 0; j < srrw_pkg::GROUP_BYTES; j++) begin
        gsum[g] = gsum[g] + GW'($signed(norm_pay[8*(g*srrw_pkg::GROUP_BYTES + j) +: 8]));
      end
    end
  end

  // Group sums folded together with the sequence number.
  always_comb begin
    gtotal = WW'(in_q.received_seq);
    for (int g = 0; g < srrw_pkg::GROUPS; g++) begin
      gtotal = gtotal + {{(WW - GW){gsum_q[g][GW-1]}}, gsum_q[g]};
    end
  end

  // Checksum and window tests.
  assign sum_ok  = (psum_q + $unsigned(in_q.received_ack)) == $unsigned(in_q.received_checksum);
  assign seq_x   = (WW + 1)'(in_q.received_seq);
  assign base_x  = {1'b0, base_q};
  assign w_x     = (WW + 1)'(eff_w);
  assign below   = (seq_x + w_x) < base_x;
  assign above   = seq_x >= (base_x + w_x);
  assign is_old  = seq_x < base_x;
  assign at_base = (seq_x == base_x);
  assign pass    = sum_ok && !below && !above;
  assign diff_x  = seq_x - base_x;
  assign seq_idx = slot_add(base_idx_q, diff_x[IdxW-1:0]);

  assign deliver_num = base_q + WW'(scan_cnt_q);

  // Controller.
  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    base_idx_d  = base_idx_q;
    scan_idx_d  = scan_idx_q;
    scan_cnt_d  = scan_cnt_q;
    pend_num_d  = pend_num_q;
    pend_pay_d  = pend_pay_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = scan_idx_q;
    mem_wdata   = '{filled: 1'b0, payload: norm_q};
    mem_raddr   = slot_add(scan_idx_q, IdxW'(1));
    case (state_q)
      ST_CLEAR: begin
        mem_we     = 1'b1;
        scan_idx_d = scan_idx_q + IdxW'(1);
        if (scan_idx_q == IdxW'(WINDOW_SLOTS - 1)) begin
          scan_idx_d = '0;
          state_d    = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = ST_IDLE;
        if (pass) begin
          res_valid_d = 1'b1;
          res_d = '{result_kind:      srrw_pkg::KIND_ACK,
                    packet_number:    in_q.received_seq,
                    ack_checksum:     $signed(psum_q + srrw_pkg::ACK_SEQ),
                    out_payload_low:  norm_q[63:0],
                    out_payload_mid:  norm_q[127:64],
                    out_payload_high: norm_q[159:128],
                    last_of_run:      !at_base};
          if (!is_old) begin
            // The packet at the base is delivered at once, so its slot stays empty.
            mem_we    = 1'b1;
            mem_waddr = seq_idx;
            mem_wdata = '{filled: !at_base, payload: norm_q};
          end
          if (at_base) begin
            pend_num_d = in_q.received_seq;
            pend_pay_d = norm_q;
            scan_cnt_d = CW'(1);
            scan_idx_d = slot_add(base_idx_q, IdxW'(1));
            mem_raddr  = slot_add(base_idx_q, IdxW'(1));
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // rd_q holds the slot at base + scan_cnt_q.
        res_valid_d = 1'b1;
        res_d = '{result_kind:      srrw_pkg::KIND_DELIVER,
                  packet_number:    pend_num_q,
                  ack_checksum:     '0,
                  out_payload_low:  pend_pay_q[63:0],
                  out_payload_mid:  pend_pay_q[127:64],
                  out_payload_high: pend_pay_q[159:128],
                  last_of_run:      1'b1};
        if ((scan_cnt_q < eff_w) && rd_q.filled) begin
          res_d.last_of_run = 1'b0;
          pend_num_d = deliver_num[SW-1:0];
          pend_pay_d = rd_q.payload;
          mem_we     = 1'b1;
          mem_waddr  = scan_idx_q;
          scan_idx_d = slot_add(scan_idx_q, IdxW'(1));
          scan_cnt_d = scan_cnt_q + CW'(1);
        end else begin
          base_d     = deliver_num;
          base_idx_d = scan_idx_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      win_size_q  <= srrw_pkg::WINDOW_SIZE_RST;
      base_q      <= '0;
      base_idx_q  <= '0;
      scan_idx_q  <= '0;
      scan_cnt_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      base_idx_q  <= base_idx_d;
      scan_idx_q  <= scan_idx_d;
      scan_cnt_q  <= scan_cnt_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        win_size_q <= cfg_data_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= item_i;
    end
    if (state_q == ST_NORM) begin
      norm_q <= norm_pay;
      gsum_q <= gsum;
    end
    if (state_q == ST_SUM) begin
      psum_q <= gtotal;
    end
    pend_num_q <= pend_num_d;
    pend_pay_q <= pend_pay_d;
    res_q      <= res_d;
  end

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // The final beat of a run is never followed straight away by another beat.
  a_last_then_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last_of_run |=> !result_valid_o)
    else $error("result beat follows the final beat of a run");

  // A delivery beat always follows the acknowledgement or another delivery.
  a_deliver_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.result_kind == srrw_pkg::KIND_DELIVER)
      |-> $past(result_valid_o))
    else $error("delivery beat without a preceding beat");

  // The scan never runs past the effective window.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (scan_cnt_q <= eff_w) && (scan_cnt_q != '0))
    else $error("delivery scan outside the window");

  // Ring writes stay inside the slot memory.
  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ({1'b0, mem_waddr} < (IdxW + 1)'(WINDOW_SLOTS)))
    else $error("slot write address out of range");

endmodule

// File: verif/selective_repeat_receiver_window_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Selective-repeat receiver window checker
// Watches the packet, result and window size channels, keeps its own copy of
// the window base and slot ring, and compares every result beat field by
// field with the beats that each accepted packet should cause.
// ---------------------------------------------------------------------------
module selective_repeat_receiver_window_checker #(
  parameter int SLOTS = srrw_pkg::WINDOW_SLOTS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  srrw_pkg::packet_t           item_i,
  input  logic                        result_valid_i,
  input  srrw_pkg::result_t           result_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [srrw_pkg::CFG_W-1:0]  cfg_data_i,
  output int                          mismatches_o,
  output int                          pending_o,
  output int                          acks_o,
  output int                          deliveries_o,
  output logic [31:0]                 base_o
);
  import srrw_pkg::*;

  // The window never exceeds half the ring, nor the hardware cap.
  localparam int EFF_CAP = (WIN_CAP < SLOTS / 2) ? WIN_CAP : SLOTS / 2;

  logic [CFG_W-1:0]     window_size_q;
  logic [31:0]          window_base_q;
  logic                 slot_full [SLOTS];
  logic [PAYLOAD_W-1:0] slot_payload [SLOTS];
  result_t              awaited_beats [$];
  int                   mismatches;
  int                   acks_seen;
  int                   deliveries_seen;

  // Every byte after the first zero byte counts as zero.
  function automatic logic [PAYLOAD_W-1:0] clip_payload(packet_t p);
    logic [PAYLOAD_W-1:0] flat;
    bit                   ended;
    flat  = {p.payload_high, p.payload_mid, p.payload_low};
    ended = 1'b0;
    for (int i = 0; i < BYTES_MAX; i++) begin
      if (i >= PAYLOAD_BYTES || ended) flat[8*i +: 8] = 8'h00;
      if (flat[8*i +: 8] == 8'h00) ended = 1'b1;
    end
    return flat;
  endfunction

  // Sum of the payload bytes, each read as a signed byte.
  function automatic logic [31:0] signed_byte_sum(logic [PAYLOAD_W-1:0] pl);
    logic [31:0] sum;
    sum = '0;
    for (int i = 0; i < BYTES_MAX; i++) begin
      sum += {{24{pl[8*i+7]}}, pl[8*i +: 8]};
    end
    return sum;
  endfunction

  function automatic result_t make_beat(logic kind, logic [SEQ_W-1:0] num,
                                        logic [31:0] cks, logic [PAYLOAD_W-1:0] pl,
                                        logic last);
    result_t r;
    r.result_kind      = kind;
    r.packet_number    = num;
    r.ack_checksum     = cks;
    r.out_payload_low  = pl[63:0];
    r.out_payload_mid  = pl[127:64];
    r.out_payload_high = pl[159:128];
    r.last_of_run      = last;
    return r;
  endfunction

  task automatic report_failure(string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_failure($sformatf("%s is %h, expected %h", name, got, want));
    end
  endtask

  // Works out the acknowledgement and any in-order run for one packet.
  task automatic acknowledge_and_deliver(packet_t p);
    logic [PAYLOAD_W-1:0] pl;
    logic [31:0]          sum;
    logic [31:0]          seq32;
    logic [31:0]          num;
    longint               s;
    longint               b;
    int                   w;
    int                   k;
    int                   idx;
    result_t              tail;
    pl    = clip_payload(p);
    sum   = signed_byte_sum(pl);
    seq32 = {1'b0, p.received_seq};
    if (sum + seq32 + p.received_ack != p.received_checksum) return;
    w = (int'(window_size_q) > EFF_CAP) ? EFF_CAP : int'(window_size_q);
    s = longint'(seq32);
    b = longint'(window_base_q);
    if (s < b - w || s >= b + w) return;
    tail = make_beat(KIND_ACK, p.received_seq, sum + ACK_SEQ + seq32, pl, 1'b1);
    // Old packets are acknowledged but never stored.
    if (s >= b) begin
      idx               = seq32 % SLOTS;
      slot_full[idx]    = 1'b1;
      slot_payload[idx] = pl;
      if (seq32 == window_base_q) begin
        for (k = 0; k < w; k++) begin
          num = window_base_q + k;
          idx = num % SLOTS;
          if (!slot_full[idx]) break;
          tail.last_of_run = 1'b0;
          awaited_beats.push_back(tail);
          tail = make_beat(KIND_DELIVER, num[SEQ_W-1:0], '0, slot_payload[idx], 1'b1);
          slot_full[idx] = 1'b0;
        end
        window_base_q += k;
      end
    end
    awaited_beats.push_back(tail);
  endtask

  task automatic compare_beat(result_t got);
    result_t want;
    if (awaited_beats.size() == 0) begin
      report_failure($sformatf("result beat for packet %0d with nothing awaited",
                               got.packet_number));
      return;
    end
    want = awaited_beats.pop_front();
    if (got.result_kind === KIND_DELIVER) deliveries_seen++;
    else acks_seen++;
    check_field("result_kind", got.result_kind, want.result_kind);
    check_field("packet_number", got.packet_number, want.packet_number);
    check_field("ack_checksum", got.ack_checksum, want.ack_checksum);
    check_field("out_payload_low", got.out_payload_low, want.out_payload_low);
    check_field("out_payload_mid", got.out_payload_mid, want.out_payload_mid);
    check_field("out_payload_high", got.out_payload_high, want.out_payload_high);
    check_field("last_of_run", got.last_of_run, want.last_of_run);
  endtask

  // Results are compared before the packet of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q = WINDOW_SIZE_RST;
      window_base_q = '0;
      for (int i = 0; i < SLOTS; i++) slot_full[i] = 1'b0;
      awaited_beats.delete();
    end else begin
      if (result_valid_i) compare_beat(result_i);
      if (cfg_valid_i && cfg_ready_i) window_size_q = cfg_data_i;
      if (start_i && !busy_i) acknowledge_and_deliver(item_i);
    end
    mismatches_o <= mismatches;
    pending_o    <= awaited_beats.size();
    acks_o       <= acks_seen;
    deliveries_o <= deliveries_seen;
    base_o       <= window_base_q;
  end

endmodule

// File: verif/selective_repeat_receiver_window_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Selective-repeat receiver window testbench
// Drives directed and random data packets through the receive window under
// several window sizes and idle patterns; a checker beside the block
// predicts every acknowledgement and delivery beat and counts mismatches.
// ---------------------------------------------------------------------------
module selective_repeat_receiver_window_tb;
  import srrw_pkg::*;

  // Longest packet: the acknowledgement plus a full run of deliveries.
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_GAP       = 20;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              start     = 1'b0;
  logic              busy;
  packet_t           item      = '0;
  logic              result_valid;
  result_t           result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data  = '0;

  int                mismatches;
  int                pending;
  int                acks;
  int                deliveries;
  logic [31:0]       window_base;

  int                idle_pct     = 0;
  int                eff_window   = 0;
  int                packets_sent = 0;
  int                settings     = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  selective_repeat_receiver_window u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item),
    .result_valid_o (result_valid),
    .result_o       (result),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  selective_repeat_receiver_window_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .item_i         (item),
    .result_valid_i (result_valid),
    .result_i       (result),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .acks_o         (acks),
    .deliveries_o   (deliveries),
    .base_o         (window_base)
  );

  // Random payload with frequent zero and sign-boundary bytes.
  function automatic logic [PAYLOAD_W-1:0] random_payload();
    logic [PAYLOAD_W-1:0] pl;
    for (int i = 0; i < BYTES_MAX; i++) begin
      case ($urandom_range(39))
        0:       pl[8*i +: 8] = 8'h00;
        1:       pl[8*i +: 8] = 8'h80;
        2:       pl[8*i +: 8] = 8'hFF;
        3:       pl[8*i +: 8] = 8'h7F;
        default: pl[8*i +: 8] = 8'($urandom_range(255));
      endcase
    end
    return pl;
  endfunction

  // Sends one packet with a correct checksum, or one with a bit flipped.
  task automatic send_packet(logic [SEQ_W-1:0] seq, logic [31:0] ack,
                             logic [PAYLOAD_W-1:0] pl, bit corrupt);
    packet_t     p;
    logic [31:0] sum;
    bit          ended;
    int          gap;
    sum   = {1'b0, seq} + ack;
    ended = 1'b0;
    for (int i = 0; i < BYTES_MAX; i++) begin
      if (pl[8*i +: 8] == 8'h00) ended = 1'b1;
      if (!ended) sum += {{24{pl[8*i+7]}}, pl[8*i +: 8]};
    end
    p.received_seq      = seq;
    p.received_ack      = ack;
    p.received_checksum = corrupt ? sum ^ (32'd1 << $urandom_range(31)) : sum;
    p.payload_low       = pl[63:0];
    p.payload_mid       = pl[127:64];
    p.payload_high      = pl[159:128];
    item  <= p;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    packets_sent++;
    gap = 0;
    while (idle_pct > 0 && gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Lowers start and waits until the block has finished its packet.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (busy);
  endtask

  // Waits for every awaited beat, then lets a dropped packet finish too.
  task automatic drain_and_pause();
    wait_idle();
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(logic [CFG_W-1:0] size);
    cfg_data  <= size;
    cfg_valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid  <= 1'b0;
    eff_window = (int'(size) > WIN_CAP) ? WIN_CAP : int'(size);
    settings++;
  endtask

  // Mostly shuffled runs of in-window packets, with window edges and noise mixed in.
  task automatic random_phase(int budget, int pct);
    int     first;
    int     n;
    int     j;
    int     tmp;
    int     offs [WIN_CAP];
    longint b;
    longint t;
    logic [SEQ_W-1:0] seq;
    idle_pct = pct;
    first    = packets_sent;
    while (packets_sent - first < budget) begin
      case ($urandom_range(99)) inside
        [0:64]: begin
          if (eff_window > 0) begin
            wait_idle();
            b = longint'(window_base);
            n = $urandom_range(1, eff_window);
            for (int i = 0; i < n; i++) offs[i] = i;
            for (int i = n - 1; i > 0; i--) begin
              j       = $urandom_range(i);
              tmp     = offs[i];
              offs[i] = offs[j];
              offs[j] = tmp;
            end
            for (int i = 0; i < n; i++) begin
              seq = SEQ_W'(b + offs[i]);
              send_packet(seq, $urandom, random_payload(), $urandom_range(19) == 0);
              if ($urandom_range(9) == 0) send_packet(seq, $urandom, random_payload(), 1'b0);
            end
          end
        end
        [65:84]: begin
          wait_idle();
          b = longint'(window_base);
          case ($urandom_range(5))
            0:       t = b - eff_window - 1;
            1:       t = b - eff_window;
            2:       t = b - 1;
            3:       t = b + eff_window - 1;
            4:       t = b + eff_window;
            default: t = b + $urandom_range(eff_window + 3);
          endcase
          if (t < 0) t = 0;
          if (t > 64'h7FFF_FFFF) t = 64'h7FFF_FFFF;
          send_packet(SEQ_W'(t), $urandom, random_payload(), 1'b0);
        end
        default: begin
          send_packet(SEQ_W'($urandom), $urandom, {$urandom, $urandom, $urandom,
                      $urandom, $urandom}, $urandom_range(1) == 1);
        end
      endcase
    end
  endtask

  // Directed packets first, then random phases under several window sizes.
  initial begin
    logic [PAYLOAD_W-1:0] pl;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The size register may be written while the slot ring is being cleared.
    write_window(WINDOW_SIZE_RST);
    idle_pct = 0;
    send_packet(31'd0, 32'd0, '0, 1'b0);
    send_packet(31'd2, 32'h7FFF_FFFF, {20{8'hFF}}, 1'b0);
    send_packet(31'd3, 32'h8000_0000, {20{8'h80}}, 1'b0);
    send_packet(31'd1, 32'hFFFF_FFFF, random_payload(), 1'b0);
    // Old packet, bad checksum, just past the window, top edge and duplicate.
    send_packet(31'd0, $urandom, random_payload(), 1'b0);
    send_packet(31'd4, $urandom, random_payload(), 1'b1);
    send_packet(31'd12, $urandom, random_payload(), 1'b0);
    send_packet(31'd11, $urandom, random_payload(), 1'b0);
    send_packet(31'd11, $urandom, random_payload(), 1'b0);
    pl = random_payload();
    pl[8*9 +: 8]  = 8'h00;
    pl[8*10 +: 8] = 8'h5A;
    send_packet(31'd5, $urandom, pl, 1'b0);
    send_packet(31'h7FFF_FFFF, $urandom, random_payload(), 1'b0);
    for (int s = 6; s <= 10; s++) send_packet(SEQ_W'(s), $urandom, random_payload(), 1'b0);
    // Fills the gap at the base and releases a full run of eight.
    send_packet(31'd4, $urandom, random_payload(), 1'b0);
    // Oldest packet still acknowledged, then the first one below it.
    send_packet(31'd4, $urandom, random_payload(), 1'b0);
    send_packet(31'd3, $urandom, random_payload(), 1'b0);
    drain_and_pause();

    write_window(6'd1);
    random_phase(30, 68);
    drain_and_pause();
    write_window(6'd32);
    random_phase(35, 23);
    drain_and_pause();
    write_window(6'd63);
    random_phase(30, 0);
    drain_and_pause();
    write_window(6'd0);
    random_phase(6, 68);
    drain_and_pause();
    write_window(CFG_W'($urandom_range(2, 31)));
    random_phase(40, 68);
    drain_and_pause();
    write_window(CFG_W'($urandom_range(2, 31)));
    random_phase(40, 23);
    drain_and_pause();

    $display("Sent %0d packets under %0d window sizes, from zero to the saturated maximum.",
             packets_sent, settings);
    $display("Compared %0d acknowledgements and %0d in-order deliveries.", acks, deliveries);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Timed out with %0d beats still awaited.", pending);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
